>>> hw/rtl/gle_pkg.sv
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types and fixed constants for the GIF LZW pixel encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

    // Sequencer state vector
    typedef logic [3:0] t_state;

    // Input item action codes
    typedef enum logic { ACT_PIXEL = 1'b0, ACT_FINISH = 1'b1 } t_action;

    // Multiplicative hash constant on the pixel value
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Byte size of the packed code stream
    localparam int unsigned BYTE_BITS = 8;

endpackage

>>> hw/rtl/gle_ram.sv
// ----------------------------------------------------------------------------
// gle_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gle_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/gif_lzw_pixel_encoder.sv
// Flow: the first item after reset or a finish emits a clear code. A pixel that opens a
//   string is taken at once; otherwise the dictionary is probed: a hit extends the string,
//   a miss emits the prefix and adds an entry. A finish emits any open prefix, EOI, last bits.
// Throughput: one item at a time, one dictionary probe per cycle; output stalls hold bytes.
// Reset: synchronous, active low; the dictionary (HASH_DEPTH entries, 8192 by default)
//   is then swept, and again after every table clear and finish.
// ----------------------------------------------------------------------------
// gif_lzw_pixel_encoder
// LZW compressor for palette pixels with variable code width, packing codes
// LSB first into bytes. Dictionary held in a hashed, linearly probed RAM.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_encoder #(
    parameter int MAX_CODES  = 4096,
    parameter int PIXEL_BITS = 5,
    parameter int HASH_DEPTH = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);

    localparam int CB = $clog2(MAX_CODES);
    localparam int HB = $clog2(HASH_DEPTH);
    localparam int EW = 1 + 2 * CB + PIXEL_BITS;
    localparam int AW = CB + gle_pkg::BYTE_BITS;
    localparam int WW = $clog2(CB + 1);
    localparam logic [CB-1:0] CODE_CLEAR = CB'(1 << PIXEL_BITS);
    localparam logic [CB-1:0] CODE_EOI   = CB'((1 << PIXEL_BITS) + 1);
    localparam logic [CB:0]   CODE_FIRST = (CB + 1)'((1 << PIXEL_BITS) + 2);
    localparam logic [WW-1:0] WIDTH_INIT = WW'(PIXEL_BITS + 1);
    localparam logic [CB-1:0] LIMIT_INIT = CB'((1 << (PIXEL_BITS + 1)) - 1);
    localparam logic [CB:0]   CODE_TOP   = (CB + 1)'(MAX_CODES - 1);

    localparam gle_pkg::t_state S_SWEEP    = 4'd0;
    localparam gle_pkg::t_state S_IDLE     = 4'd1;
    localparam gle_pkg::t_state S_START    = 4'd2;
    localparam gle_pkg::t_state S_DISPATCH = 4'd3;
    localparam gle_pkg::t_state S_PROBE    = 4'd4;
    localparam gle_pkg::t_state S_MISS     = 4'd5;
    localparam gle_pkg::t_state S_FULL     = 4'd6;
    localparam gle_pkg::t_state S_TBL_CLR  = 4'd7;
    localparam gle_pkg::t_state S_FIN_EOI  = 4'd8;
    localparam gle_pkg::t_state S_FIN_PAD  = 4'd9;
    localparam gle_pkg::t_state S_FIN_END  = 4'd10;
    localparam gle_pkg::t_state S_DRAIN    = 4'd11;

    gle_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic                  r_action;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [CB-1:0]         r_prefix, n_prefix;
    logic                  r_pvalid, n_pvalid;
    logic [CB:0]           r_next_code, n_next_code;
    logic [WW-1:0]         r_width, n_width;
    logic [CB-1:0]         r_limit, n_limit;
    logic [7:0]            r_buf, n_buf;
    logic [2:0]            r_cnt, n_cnt;
    logic                  r_started, n_started;
    logic [AW-1:0]         r_acc, n_acc;
    logic [4:0]            r_total, n_total;
    logic                  r_last_phase, n_last_phase;
    logic [HB-1:0]         r_addr, n_addr;
    logic [HB:0]           r_sweep, n_sweep;
    logic                  r_ovalid, n_ovalid;
    logic [7:0]            r_obyte, n_obyte;
    logic                  r_olast, n_olast;

    logic          ram_we;
    logic [HB-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic          e_valid;
    logic [CB-1:0] e_prefix, e_code;
    logic [PIXEL_BITS-1:0] e_pix;
    logic [31:0]   hash_full;
    logic          put_en;
    logic [CB-1:0] put_code;
    logic          out_free;

    assign {e_valid, e_prefix, e_pix, e_code} = ram_rdata;
    assign hash_full = (32'(r_prefix) << PIXEL_BITS) ^ (32'(r_pix) * gle_pkg::HASH_MULT);
    assign out_free  = !r_ovalid || i_ready;

    gle_ram #(.WIDTH(EW), .DEPTH(HASH_DEPTH)) u_dict (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_prefix     = r_prefix;
        n_pvalid     = r_pvalid;
        n_next_code  = r_next_code;
        n_width      = r_width;
        n_limit      = r_limit;
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_started    = r_started;
        n_acc        = r_acc;
        n_total      = r_total;
        n_last_phase = r_last_phase;
        n_addr       = r_addr;
        n_sweep      = r_sweep;
        n_ovalid     = r_ovalid && !i_ready;
        n_obyte      = r_obyte;
        n_olast      = r_olast && r_ovalid && !i_ready;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = {1'b0, r_prefix, r_pix, r_next_code[CB-1:0]};
        ram_raddr    = HB'(hash_full);
        put_en       = 1'b0;
        put_code     = CODE_CLEAR;

        unique case (r_state)
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep[HB-1:0];
                ram_wdata = '0;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == (HB + 1)'(HASH_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DISPATCH;
                if (!r_started) begin
                    n_started = 1'b1;
                    put_en    = 1'b1;
                    put_code  = CODE_CLEAR;
                    n_ret     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_action == gle_pkg::ACT_PIXEL) begin
                    if (!r_pvalid) begin
                        n_prefix = CB'(r_pix);
                        n_pvalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_addr  = HB'(hash_full);
                        n_state = S_PROBE;
                    end
                end else begin
                    n_state = S_FIN_EOI;
                    if (r_pvalid) begin
                        put_en   = 1'b1;
                        put_code = r_prefix;
                        n_ret    = S_FIN_EOI;
                    end
                end
            end
            S_PROBE: begin
                if (!e_valid) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, r_prefix, r_pix, r_next_code[CB-1:0]};
                    put_en    = 1'b1;
                    put_code  = r_prefix;
                    n_ret     = S_MISS;
                end else if (e_prefix == r_prefix && e_pix == r_pix) begin
                    n_prefix = e_code;
                    n_state  = S_IDLE;
                end else begin
                    // linear probe to the next slot
                    n_addr    = r_addr + 1'b1;
                    ram_raddr = r_addr + 1'b1;
                end
            end
            S_MISS: begin
                if (r_next_code > (CB + 1)'(r_limit)) begin
                    n_limit = {r_limit[CB-2:0], 1'b1};
                    n_width = r_width + 1'b1;
                end
                n_next_code = r_next_code + 1'b1;
                n_prefix    = CB'(r_pix);
                n_state     = (r_next_code + 1'b1 > CODE_TOP) ? S_FULL : S_IDLE;
            end
            S_FULL: begin
                put_en   = 1'b1;
                put_code = CODE_CLEAR;
                n_ret    = S_TBL_CLR;
            end
            S_TBL_CLR: begin
                n_next_code = CODE_FIRST;
                n_width     = WIDTH_INIT;
                n_limit     = LIMIT_INIT;
                n_sweep     = '0;
                n_state     = S_SWEEP;
            end
            S_FIN_EOI: begin
                put_en       = 1'b1;
                put_code     = CODE_EOI;
                n_last_phase = 1'b1;
                n_ret        = S_FIN_PAD;
            end
            S_FIN_PAD: begin
                n_state = S_FIN_END;
                if (r_cnt != 3'd0) begin
                    n_acc   = AW'(r_buf);
                    n_total = 5'd8;
                    n_ret   = S_FIN_END;
                    n_state = S_DRAIN;
                end
            end
            S_FIN_END: begin
                n_prefix     = '0;
                n_pvalid     = 1'b0;
                n_started    = 1'b0;
                n_buf        = '0;
                n_cnt        = '0;
                n_last_phase = 1'b0;
                n_next_code  = CODE_FIRST;
                n_width      = WIDTH_INIT;
                n_limit      = LIMIT_INIT;
                n_sweep      = '0;
                n_state      = S_SWEEP;
            end
            S_DRAIN: begin
                if (r_total >= 5'd8) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_obyte  = r_acc[7:0];
                        n_olast  = r_last_phase && (r_total == 5'd8);
                        n_acc    = r_acc >> 8;
                        n_total  = r_total - 5'd8;
                    end
                end else begin
                    n_buf   = r_acc[7:0];
                    n_cnt   = r_total[2:0];
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_SWEEP;
                n_sweep = '0;
            end
        endcase

        // code joins the bit accumulator at the current width
        if (put_en) begin
            n_acc   = AW'(r_buf) | (AW'(put_code) << r_cnt);
            n_total = 5'(r_cnt) + 5'(r_width);
            n_state = S_DRAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_ret        <= S_IDLE;
            r_pvalid     <= 1'b0;
            r_prefix     <= '0;
            r_next_code  <= CODE_FIRST;
            r_width      <= WIDTH_INIT;
            r_limit      <= LIMIT_INIT;
            r_buf        <= '0;
            r_cnt        <= '0;
            r_started    <= 1'b0;
            r_total      <= '0;
            r_last_phase <= 1'b0;
            r_sweep      <= '0;
            r_ovalid     <= 1'b0;
            r_olast      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_pvalid     <= n_pvalid;
            r_prefix     <= n_prefix;
            r_next_code  <= n_next_code;
            r_width      <= n_width;
            r_limit      <= n_limit;
            r_buf        <= n_buf;
            r_cnt        <= n_cnt;
            r_started    <= n_started;
            r_total      <= n_total;
            r_last_phase <= n_last_phase;
            r_sweep      <= n_sweep;
            r_ovalid     <= n_ovalid;
            r_olast      <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_action <= i_action;
            r_pix    <= i_pixel;
        end
        r_acc   <= n_acc;
        r_addr  <= n_addr;
        r_obyte <= n_obyte;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without valid byte");

    a_idle_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_total < 5'd8))
        else $error("whole byte left in accumulator while idle");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width >= WIDTH_INIT) && (32'(r_width) <= CB))
        else $error("code width out of range");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_next_code <= CODE_TOP))
        else $error("next code beyond table while idle");

endmodule
